/* src/stns_pkg.sv */
`timescale 1ns / 1ps

package stns_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W = 64;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_CMP,
        ST_DONE
    } stns_state_t;

endpackage

/* src/stns_ram.sv */
`timescale 1ns / 1ps

module stns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/stns_cfg.sv */
`timescale 1ns / 1ps

module stns_cfg
    import stns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CNT_W-1:0]  entry_count
);

    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;
    logic             hit;

    assign hit = (paddr[APB_AW-1] == REG_ENTRY_COUNT);

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (psel && penable && pwrite && hit)
        begin
            entry_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    assign prdata = hit ? {(APB_DW - CNT_W)'(0), entry_count_reg} : '0;
    assign pready = 1'b1;
    assign entry_count = entry_count_reg;

endmodule

/* src/stns_engine.sv */
`timescale 1ns / 1ps

module stns_engine
    import stns_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] entry_count,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  logic [IDX_W-1:0] entry_index,
    input  logic [KEY_W-1:0] key_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] found_index,
    output logic             none
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = (CNT_W > CW) ? CNT_W : CW;
    localparam int IW = (IDX_W > CW) ? IDX_W : CW;
    localparam logic [MW-1:0] DEPTH_M = MW'(TABLE_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

    stns_state_t      state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic             ge_first_reg, ge_first_next;
    logic [CW-1:0]    res_idx_reg, res_idx_next;
    logic             res_none_reg, res_none_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic             none_reg, none_next;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic [CW-1:0]    n_sat;
    logic [CW-1:0]    nm1;
    logic             slot_ok;
    logic [CW-1:0]    lo_n;
    logic [CW-1:0]    hi_n;
    logic             brk;
    logic [CW:0]      mid_sum;

    assign n_sat = (MW'(entry_count) > DEPTH_M) ?
                   CW'(TABLE_DEPTH) : CW'(entry_count);
    assign nm1 = n_reg - CW'(1);
    assign slot_ok = (IW'(entry_index) < DEPTH_I);

    stns_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(entry_index)),
        .wdata (key_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        key_next = key_reg;
        n_next = n_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        ge_first_next = ge_first_reg;
        res_idx_next = res_idx_reg;
        res_none_next = res_none_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next = found_reg;
        none_next = none_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = '0;
        lo_n = lo_reg;
        hi_n = hi_reg;
        brk = 1'b0;
        mid_sum = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        ram_we = slot_ok;
                    end
                    else
                    begin
                        key_next = key_value;
                        n_next = n_sat;
                        ram_re = 1'b1;
                        ram_raddr = '0;
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                ge_first_next = (key_reg >= ram_rdata);
                if (n_reg == '0)
                begin
                    res_idx_next = '0;
                    res_none_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re = 1'b1;
                    ram_raddr = nm1[AW-1:0];
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if ((n_reg > CW'(1)) && ge_first_reg && (key_reg < ram_rdata))
                begin
                    lo_next = '0;
                    hi_next = nm1;
                    mid_next = nm1 >> 1;
                    ram_re = 1'b1;
                    ram_raddr = mid_next[AW-1:0];
                    state_next = ST_CMP;
                end
                else if (key_reg >= ram_rdata)
                begin
                    res_idx_next = nm1;
                    res_none_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    res_idx_next = '0;
                    res_none_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    res_idx_next = mid_reg;
                    res_none_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (ram_rdata < key_reg)
                    begin
                        lo_n = mid_reg + CW'(1);
                    end
                    else if (mid_reg == '0)
                    begin
                        brk = 1'b1;
                    end
                    else
                    begin
                        hi_n = mid_reg - CW'(1);
                    end
                    lo_next = lo_n;
                    hi_next = hi_n;
                    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
                    if (!brk && (lo_n <= hi_n))
                    begin
                        mid_next = mid_sum[CW:1];
                        ram_re = 1'b1;
                        ram_raddr = mid_next[AW-1:0];
                    end
                    else
                    begin
                        res_idx_next = (lo_n > nm1) ? nm1 : lo_n;
                        res_none_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next = IDX_W'(res_idx_reg);
                    none_next = res_none_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        n_reg <= n_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        ge_first_reg <= ge_first_next;
        res_idx_reg <= res_idx_next;
        res_none_reg <= res_none_next;
        found_reg <= found_next;
        none_reg <= none_next;
    end

    assign out_valid = out_valid_reg;
    assign found_index = found_reg;
    assign none = none_reg;

endmodule

/* src/sorted_table_nearest_search_top.sv */
// sorted table nearest search
// input channel (in_valid / in_stall): cmd, entry_index, key_value per beat.
//   cmd write stores key_value at entry_index; slots at or above the table
//   depth are dropped. a write gives no result beat. cmd search looks up
//   key_value among the first entry_count entries, capped at the depth.
// output channel (out_valid / out_stall): found_index and none, one beat
//   per search. none is set with found_index zero when the key lies below
//   the first entry or the table is empty.
// apb port: entry_count at byte address 0, to be written only while idle;
//   the block itself does not enforce this.
// a search reads entry 0, then the last entry, then one probe per cycle of
//   the halving loop over the table ram read port, then posts the result
//   from a done state that holds while the output register is full.
//   one search is in flight at a time; writes follow each other back to back.
// the result sits in an output register; the next beat is taken while it
//   waits, and a finished search holds until that register is free.
// reset clears entry_count and the control state; table contents are
//   undefined until written and need no clearing pass.
`timescale 1ns / 1ps

module sorted_table_nearest_search_top
    import stns_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [KEY_W-1:0]  key_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  found_index,
    output logic              none,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0] entry_count;

    stns_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count)
    );

    stns_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found_index (found_index),
        .none        (none)
    );

endmodule

/* src/stns_checker.sv */
`timescale 1ns / 1ps

module stns_checker
    import stns_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             cmd,
    input logic             out_valid,
    input logic             out_stall,
    input logic [IDX_W-1:0] found_index,
    input logic             none
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat during reset");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none |-> found_index == '0)
        else $error("none result with nonzero index");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_SEARCH |=> in_stall)
        else $error("search beat did not occupy the engine");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_WRITE |=> !in_stall)
        else $error("write beat left the engine busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found_index) && $stable(none))
        else $error("stalled result beat changed");

endmodule

bind sorted_table_nearest_search_top stns_checker u_stns_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import stns_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    localparam int FILL_SPREAD = 0;
    localparam int FILL_CLUSTERED = 1;
    localparam int FILL_SCRAMBLED = 2;

    localparam int PACE_FREE = 0;
    localparam int PACE_SLOW_SEND = 1;
    localparam int PACE_SLOW_DRAIN = 2;
    localparam int PACE_BOTH = 3;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] slot;
        logic [KEY_W-1:0] key;
    } table_beat_t;

    typedef struct packed {
        logic             none;
        logic [IDX_W-1:0] idx;
    } hit_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_WRITE;
    logic [IDX_W-1:0]  entry_index = '0;
    logic [KEY_W-1:0]  key_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [IDX_W-1:0]  found_index;
    logic              none;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    table_beat_t pending_beats[$];
    table_beat_t next_beat;
    hit_t        expected_hits[$];
    hit_t        want;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH_DEF];
    logic [KEY_W-1:0] plan_mem [TABLE_DEPTH_DEF];
    logic [CNT_W-1:0] count_cfg = '0;

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;

    sorted_table_nearest_search_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .entry_index(entry_index),
        .key_value(key_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found_index(found_index),
        .none(none),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic hit_t nearest_entry(input logic [KEY_W-1:0] key);
        int   n;
        int   lo;
        int   hi;
        int   mid;
        hit_t r;
        n = (count_cfg > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(count_cfg);
        r.none = 1'b0;
        r.idx = '0;
        if (n > 1 && key_mem[0] <= key && key < key_mem[n-1])
        begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (key_mem[mid] == key)
                begin
                    r.idx = IDX_W'(mid);
                    return r;
                end
                if (key_mem[mid] < key)
                    lo = mid + 1;
                else
                begin
                    if (mid == 0)
                        break;
                    hi = mid - 1;
                end
            end
            if (lo > n - 1)
                lo = n - 1;
            r.idx = IDX_W'(lo);
        end
        else if (n == 1 && key_mem[0] == key)
            r.idx = '0;
        else if (n > 0 && key >= key_mem[n-1])
            r.idx = IDX_W'(n - 1);
        else
            r.none = 1'b1;
        return r;
    endfunction

    // driver: a new beat only once the current one is gone
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                in_valid <= 1'b1;
                cmd <= next_beat.cmd;
                entry_index <= next_beat.slot;
                key_value <= next_beat.key;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_WRITE)
                    key_mem[entry_index] = key_value;
                else
                    expected_hits.push_back(nearest_entry(key_value));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result beat: index %0d none %0b",
                             $time, found_index, none);
                    fail_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (found_index !== want.idx)
                    begin
                        $display("%0t: found_index expected %0d actual %0d",
                                 $time, want.idx, found_index);
                        fail_count++;
                    end
                    if (none !== want.none)
                    begin
                        $display("%0t: none expected %0b actual %0b",
                                 $time, want.none, none);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("sorted_table_nearest_search_top: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_pace(input int mode);
        case (mode)
            PACE_FREE:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            PACE_SLOW_SEND:
            begin
                send_idle_pct = 70;
                stall_pct = 0;
            end
            PACE_SLOW_DRAIN:
            begin
                send_idle_pct = 0;
                stall_pct = 70;
            end
            default:
            begin
                send_idle_pct = 33;
                stall_pct = 33;
            end
        endcase
    endtask

    task automatic push_write(input int slot, input logic [KEY_W-1:0] key);
        table_beat_t b;
        b.cmd = CMD_WRITE;
        b.slot = IDX_W'(slot);
        b.key = key;
        plan_mem[slot] = key;
        pending_beats.push_back(b);
    endtask

    task automatic push_search(input logic [KEY_W-1:0] key);
        table_beat_t b;
        b.cmd = CMD_SEARCH;
        b.slot = IDX_W'($urandom_range(TABLE_DEPTH_DEF - 1));
        b.key = key;
        pending_beats.push_back(b);
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ENTRY_COUNT, 2'b00};
        pwdata <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        count_cfg = CNT_W'(value);
    endtask

    task automatic load_table(input int n, input int style);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] step;
        int               i;
        k = {$urandom, $urandom} >> $urandom_range(0, 63);
        for (i = 0; i < n; i++)
        begin
            if (style == FILL_SCRAMBLED)
                k = {$urandom, $urandom};
            else if (i != 0)
            begin
                if (style == FILL_CLUSTERED)
                    step = KEY_W'($urandom_range(2));
                else
                    step = {$urandom, $urandom} >> $urandom_range(10, 63);
                k = (KEY_MAX - k < step) ? KEY_MAX : k + step;
            end
            push_write(i, k);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int n);
        logic [KEY_W-1:0] r;
        logic [KEY_W-1:0] gap;
        int               i;
        r = {$urandom, $urandom};
        if (n == 0)
            return ($urandom_range(3) == 0) ? KEY_MAX : r;
        i = $urandom_range(n - 1);
        case ($urandom_range(8))
            0, 1: return plan_mem[i];
            2: return plan_mem[i] + 1;
            3: return plan_mem[i] - 1;
            4:
            begin
                if (i == n - 1)
                    return r;
                gap = plan_mem[i+1] - plan_mem[i];
                return (gap == 0) ? plan_mem[i] : plan_mem[i] + r % gap;
            end
            5: return (plan_mem[0] == 0) ? r : r % plan_mem[0];
            6: return plan_mem[n-1] | (r >> $urandom_range(1, 63));
            7: return $urandom_range(1) ? KEY_MAX : {KEY_W{1'b0}};
            default: return r;
        endcase
    endfunction

    task automatic run_searches(input int n, input int count, input bit noisy);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (noisy && $urandom_range(9) == 0)
                push_write($urandom_range(TABLE_DEPTH_DEF - 1), {$urandom, $urandom});
            else
                push_search(pick_key(n));
        end
    endtask

    task automatic edge_searches();
        push_search(0);
        push_search(50);
        push_search(500);
        push_search(1000);
        push_search(KEY_MAX);
    endtask

    initial
    begin
        int ph;
        int n;
        int style;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small hand-built tables, with an empty table first
        set_pace(PACE_FREE);
        push_write(0, 10);
        push_write(1, 20);
        push_write(2, 20);
        push_write(3, 40);
        push_write(TABLE_DEPTH_DEF - 1, KEY_MAX);
        push_search(10);
        settle();
        set_entry_count(1);
        push_search(9);
        push_search(10);
        push_search(11);
        push_search(KEY_MAX);
        settle();
        set_entry_count(4);
        push_search(0);
        push_search(10);
        push_search(15);
        push_search(20);
        push_search(39);
        push_search(40);
        push_search(KEY_MAX);
        settle();
        push_write(0, 50);
        push_write(1, 50);
        settle();
        set_entry_count(2);
        push_search(49);
        push_search(50);
        push_search(51);
        settle();
        set_entry_count(0);
        push_search(0);
        settle();

        // first, middle and last slots only, counts at and past the depth
        set_pace(PACE_SLOW_DRAIN);
        push_write(0, 100);
        push_write(TABLE_DEPTH_DEF / 2 - 1, 500);
        push_write(TABLE_DEPTH_DEF - 1, 1000);
        settle();
        set_entry_count(TABLE_DEPTH_DEF);
        edge_searches();
        settle();
        set_pace(PACE_SLOW_SEND);
        set_entry_count((1 << CNT_W) - 1);
        edge_searches();
        settle();
        set_entry_count(TABLE_DEPTH_DEF + 1);
        edge_searches();
        settle();

        for (ph = 0; ph < 10; ph++)
        begin
            set_pace(ph % 4);
            n = $urandom_range(99);
            if (n < 8)
                n = 0;
            else if (n < 16)
                n = 1;
            else if (n < 24)
                n = 2;
            else if (n < 90)
                n = $urandom_range(3, 40);
            else
                n = $urandom_range(41, 100);
            if (ph % 5 == 4)
                style = FILL_SCRAMBLED;
            else if ($urandom_range(3) == 0)
                style = FILL_CLUSTERED;
            else
                style = FILL_SPREAD;
            load_table(n, style);
            settle();
            set_entry_count(n);
            run_searches(n, 20, 1'b1);
            // long output hold while searches keep coming
            if (ph == 6)
                hold_requests++;
            settle();
        end

        if (fail_count == 0)
            $display("sorted_table_nearest_search_top: match");
        else
            $display("sorted_table_nearest_search_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/stns_pkg.sv
src/stns_ram.sv
src/stns_cfg.sv
src/stns_engine.sv
src/sorted_table_nearest_search_top.sv
src/stns_checker.sv
bench/testbench.sv
